// ===== sv/isort_pkg.sv =====
package isort_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int KEY_BITS_DEF = 16;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;  // insert the broadcast key
    logic pop;  // shift the whole chain one place towards cell 0
  } cell_ctl_t;

endpackage

// ===== sv/isort_if.sv =====
interface isort_in_if #(
  parameter int KEY_BITS = isort_pkg::KEY_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key_value;
  logic                final_key;

  modport source (output valid, output key_value, output final_key, input ready);
  modport sink   (input valid, input key_value, input final_key, output ready);
endinterface

interface isort_out_if #(
  parameter int KEY_BITS = isort_pkg::KEY_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] sorted_value;
  logic                run_end;
  logic                dropped_keys;

  modport source (output valid, output sorted_value, output run_end, output dropped_keys,
                  input ready);
  modport sink   (input valid, input sorted_value, input run_end, input dropped_keys,
                  output ready);
endinterface

// ===== sv/isort_cell.sv =====
module isort_cell #(
  parameter int KEY_BITS = isort_pkg::KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  isort_pkg::cell_ctl_t ctl,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic                left_occ,
  input  logic                left_gt,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic                right_occ,
  input  logic [KEY_BITS-1:0] right_key,
  output logic                occ,
  output logic                gt,
  output logic [KEY_BITS-1:0] key
);

  logic                occ_r, occ_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;

  // strictly greater keeps equal keys in arrival order
  assign gt  = occ_r && (key_r > new_key);
  assign occ = occ_r;
  assign key = key_r;

  always_comb begin
    occ_nxt = occ_r;
    key_nxt = key_r;
    if (ctl.pop) begin
      occ_nxt = right_occ;
      key_nxt = right_key;
    end else if (ctl.ins) begin
      priority if (gt) begin
        key_nxt = left_gt ? left_key : new_key;
      end else if (!occ_r) begin
        occ_nxt = left_occ;
        key_nxt = left_gt ? left_key : new_key;
      end else begin
        key_nxt = key_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
    key_r <= key_nxt;
  end

endmodule

// ===== sv/insertion_sorter_core.sv =====
// input: a key is placed in the cell chain at the edge that accepts it, one key per cycle;
// a key taken while the chain is full is dropped and sets the overflow flag
// output: the final key's transaction sets the drain state, from which results are registered
// into the output register one per cycle while the receiver takes them, by the single drain
// path through cell 0; no input is taken while the chain drains
// reset: all cells empty, overflow flag and output valid cleared, ready for input
module insertion_sorter_core #(
  parameter int MAX_KEYS = isort_pkg::MAX_KEYS_DEF,
  parameter int KEY_BITS = isort_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  isort_in_if.sink    in_if,
  isort_out_if.source out_if
);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   ovf_r, ovf_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_end_r, out_end_nxt;
  logic   out_drop_r, out_drop_nxt;
  logic [KEY_BITS-1:0] out_key_r, out_key_nxt;

  logic [MAX_KEYS-1:0] occ_w;
  logic [MAX_KEYS-1:0] gt_w;
  logic [KEY_BITS-1:0] key_w [MAX_KEYS];

  isort_pkg::cell_ctl_t ctl;
  logic in_acc;
  logic full;
  logic last_pop;

  assign in_if.ready = (state_r == ST_LOAD);
  assign in_acc      = in_if.valid && in_if.ready;
  assign full        = occ_w[MAX_KEYS-1];

  assign ctl.ins  = in_acc && !full;
  assign ctl.pop  = (state_r == ST_DRAIN) && (!out_valid_r || out_if.ready);
  assign last_pop = ctl.pop && !occ_w[1];

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    logic                l_occ, l_gt, r_occ;
    logic [KEY_BITS-1:0] l_key, r_key;

    if (i == 0) begin : g_head
      // head cell behaves as if a smaller key sits to its left
      assign l_occ = 1'b1;
      assign l_gt  = 1'b0;
      assign l_key = '0;
    end else begin : g_body
      assign l_occ = occ_w[i-1];
      assign l_gt  = gt_w[i-1];
      assign l_key = key_w[i-1];
    end

    if (i == MAX_KEYS - 1) begin : g_tail
      assign r_occ = 1'b0;
      assign r_key = '0;
    end else begin : g_mid
      assign r_occ = occ_w[i+1];
      assign r_key = key_w[i+1];
    end

    isort_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .new_key   (in_if.key_value),
      .left_occ  (l_occ),
      .left_gt   (l_gt),
      .left_key  (l_key),
      .right_occ (r_occ),
      .right_key (r_key),
      .occ       (occ_w[i]),
      .gt        (gt_w[i]),
      .key       (key_w[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_end_nxt   = out_end_r;
    out_drop_nxt  = out_drop_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end
          if (in_if.final_key) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (ctl.pop) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = key_w[0];
          out_end_nxt   = !occ_w[1];
          out_drop_nxt  = ovf_r;
          if (last_pop) begin
            state_nxt = ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_key_r  <= out_key_nxt;
    out_end_r  <= out_end_nxt;
    out_drop_r <= out_drop_nxt;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.sorted_value = out_key_r;
  assign out_if.run_end      = out_end_r;
  assign out_if.dropped_keys = out_drop_r;

  // occupied cells always form an unbroken run from cell 0
  a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_w & (occ_w + 1'b1)) == '0)
    else $error("cell occupancy has a gap");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> occ_w[0])
    else $error("draining with an empty chain");

  a_final_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.final_key) |=> (state_r == ST_DRAIN))
    else $error("final key did not start the drain");

  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    last_pop |=> (occ_w == '0) && !ovf_r)
    else $error("chain not empty after the last result");

endmodule
